[hw/rtl/itp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package itp_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
   localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_CARET    = 8'h5E;
   localparam logic [7:0] CH_LPAREN   = 8'h28;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_LBRACE   = 8'h7B;
   localparam logic [7:0] CH_RPAREN   = 8'h29;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_RBRACE   = 8'h7D;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_STAR     = 8'h2A;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CH_DIGIT_0  = 8'h30;
   localparam logic [7:0] CH_DIGIT_9  = 8'h39;
   localparam logic [7:0] CH_TERM     = 8'h00;

   // rank 0 stands for precedence -1; 1..3 map directly
   localparam logic [1:0] RANK_OTHER = 2'd0;
   localparam logic [1:0] RANK_ADD   = 2'd1;
   localparam logic [1:0] RANK_MUL   = 2'd2;
   localparam logic [1:0] RANK_POW   = 2'd3;

   typedef enum logic [2:0] {
      KIND_OPERAND,
      KIND_OPEN,
      KIND_CLOSE,
      KIND_OPERATOR,
      KIND_END
   } kind_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_expr;
   } req_type;

   typedef struct packed {
      logic [7:0] out_symbol;
      logic       last;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] symbol;
      logic [7:0] opener;
      logic [1:0] rank;
   } cmd_type;

   function automatic logic [1:0] prec_rank(input logic [7:0] c);
      logic [1:0] r;
      r = RANK_OTHER;
      if (c == CH_PLUS || c == CH_MINUS) r = RANK_ADD;
      else if (c == CH_STAR || c == CH_SLASH) r = RANK_MUL;
      else if (c == CH_CARET) r = RANK_POW;
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/itp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module itp_front (
   input  wire itp_pkg::req_type req_data,
   output itp_pkg::cmd_type      cmd
);

   logic [7:0] sym;
   logic       is_operand;

   assign sym = req_data.symbol;
   assign is_operand = (sym >= itp_pkg::CH_LOWER_A && sym <= itp_pkg::CH_LOWER_Z) ||
                       (sym >= itp_pkg::CH_UPPER_A && sym <= itp_pkg::CH_UPPER_Z) ||
                       (sym >= itp_pkg::CH_DIGIT_0 && sym <= itp_pkg::CH_DIGIT_9);

   always_comb begin
      cmd.symbol = sym;
      cmd.rank   = itp_pkg::prec_rank(sym);
      cmd.opener = itp_pkg::CH_LBRACE;
      if (req_data.end_of_expr) begin
         cmd.kind = itp_pkg::KIND_END;
      end else if (is_operand) begin
         cmd.kind = itp_pkg::KIND_OPERAND;
      end else if (sym == itp_pkg::CH_LPAREN || sym == itp_pkg::CH_LBRACKET ||
                   sym == itp_pkg::CH_LBRACE) begin
         cmd.kind = itp_pkg::KIND_OPEN;
      end else if (sym == itp_pkg::CH_RPAREN || sym == itp_pkg::CH_RBRACKET ||
                   sym == itp_pkg::CH_RBRACE) begin
         cmd.kind = itp_pkg::KIND_CLOSE;
         if (sym == itp_pkg::CH_RPAREN) cmd.opener = itp_pkg::CH_LPAREN;
         else if (sym == itp_pkg::CH_RBRACKET) cmd.opener = itp_pkg::CH_LBRACKET;
      end else begin
         cmd.kind = itp_pkg::KIND_OPERATOR;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/itp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module itp_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   wr_valid,
   output logic                  wr_ready,
   input  wire itp_pkg::cmd_type wr_data,
   output logic                  rd_valid,
   input  wire                   rd_ready,
   output itp_pkg::cmd_type      rd_data
);

   itp_pkg::cmd_type                  entry_ff [itp_pkg::QUEUE_DEPTH];
   logic [itp_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [itp_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [itp_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                             do_wr, do_rd;

   assign wr_ready = (count_ff != itp_pkg::QUEUE_CNT_W'(itp_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == itp_pkg::QUEUE_PTR_W'(itp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == itp_pkg::QUEUE_PTR_W'(itp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (!do_wr && do_rd) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) entry_ff[wr_ptr_ff] <= wr_data;
   end

endmodule
`default_nettype wire

[hw/rtl/itp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module itp_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   cmd_valid,
   output logic                  cmd_ready,
   input  wire itp_pkg::cmd_type cmd,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output itp_pkg::rsp_type      rsp_data
);

   logic [7:0]                      stack_ff [itp_pkg::STACK_DEPTH];
   logic [itp_pkg::STACK_CNT_W-1:0] count_ff, count_in;
   logic                            ovf_ff, ovf_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   itp_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic [itp_pkg::STACK_CNT_W-1:0] top_pos;
   logic [7:0]                      top_sym;
   logic                            has_top, is_full, can_emit;
   logic                            emit, pop, push, done;
   itp_pkg::rsp_type                emit_data;

   assign top_pos  = count_ff - 1'b1;
   assign top_sym  = stack_ff[top_pos[itp_pkg::STACK_IDX_W-1:0]];
   assign has_top  = (count_ff != '0);
   assign is_full  = (count_ff == itp_pkg::STACK_CNT_W'(itp_pkg::STACK_DEPTH));
   assign can_emit = !rsp_valid_ff || rsp_ready;

   always_comb begin
      emit      = 1'b0;
      pop       = 1'b0;
      push      = 1'b0;
      done      = 1'b0;
      emit_data = '{out_symbol: top_sym, last: 1'b0, overflow: 1'b0};
      ovf_in    = ovf_ff;
      if (cmd_valid) begin
         case (cmd.kind)
            itp_pkg::KIND_OPERAND: begin
               emit_data.out_symbol = cmd.symbol;
               emit = can_emit;
               done = can_emit;
            end
            itp_pkg::KIND_OPEN: begin
               push = 1'b1;
               done = 1'b1;
            end
            itp_pkg::KIND_CLOSE: begin
               if (has_top && top_sym != cmd.opener) begin
                  emit = can_emit;
                  pop  = can_emit;
               end else begin
                  // discard the matching opener, or drop an unmatched closer
                  pop  = has_top;
                  done = 1'b1;
               end
            end
            itp_pkg::KIND_OPERATOR: begin
               if (has_top && cmd.rank <= itp_pkg::prec_rank(top_sym)) begin
                  emit = can_emit;
                  pop  = can_emit;
               end else begin
                  push = 1'b1;
                  done = 1'b1;
               end
            end
            itp_pkg::KIND_END: begin
               if (has_top) begin
                  emit = can_emit;
                  pop  = can_emit;
               end else begin
                  emit_data = '{out_symbol: itp_pkg::CH_TERM, last: 1'b1, overflow: ovf_ff};
                  emit = can_emit;
                  done = can_emit;
                  if (can_emit) ovf_in = 1'b0;
               end
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end

      count_in = count_ff;
      if (pop) begin
         count_in = count_ff - 1'b1;
      end else if (push) begin
         if (is_full) ovf_in = 1'b1;
         else count_in = count_ff + 1'b1;
      end

      rsp_data_in  = emit ? emit_data : rsp_data_ff;
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   assign cmd_ready = done;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (push && !is_full) stack_ff[count_ff[itp_pkg::STACK_IDX_W-1:0]] <= cmd.symbol;
   end

endmodule
`default_nettype wire

[hw/rtl/infix_to_postfix_converter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shunting-yard infix to postfix converter.
// req channel: one character per transfer (symbol, end_of_expr). The front
// classifies it and writes it into a two-entry command queue; req_ready is
// low only while that queue is full.
// rsp channel: one postfix character per transfer (out_symbol, last,
// overflow). An end item flushes the operator stack and then sends a
// terminator with out_symbol 0, last 1 and the sticky overflow flag.
// Timing: an item passes through the command queue register, and its first
// result then through the output register. Every entry that an item sends
// out from the stack needs its own stack read, one stack read per cycle while
// the output register can take a result.
// The operator stack holds 32 entries; a push onto a full stack is dropped
// and sets the overflow flag until the next terminator.
// Reset empties the queue, the stack and the output register and clears the
// overflow flag. When the receiver holds rsp_ready low, the result waits in
// the output register, the back end stalls at the next item that has a result
// to send, and the queue fills and then stalls the sender.
module infix_to_postfix_converter_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire itp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output itp_pkg::rsp_type      rsp_data
);

   itp_pkg::cmd_type front_cmd;
   itp_pkg::cmd_type queue_cmd;
   logic             queue_valid;
   logic             queue_ready;

   itp_front u_front (
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   itp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_data  (front_cmd),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready),
      .rd_data  (queue_cmd)
   );

   itp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[tb/tb_infix_to_postfix_converter_core.sv]
`timescale 1ns / 1ps
module tb_infix_to_postfix_converter_core;
   import itp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_ITEMS   = 250;
   localparam int IDLE_PERCENT   = 7;
   localparam int HOLD_START     = 200;
   localparam int HOLD_LEN       = 200;
   localparam int RX_CALM_START  = 20;
   localparam int RX_CALM_END    = 160;
   localparam int TX_CALM_FIRST  = 120;
   localparam int TX_CALM_LAST   = 180;

   localparam logic [7:0] OP_CHARS [5]     = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};
   localparam logic [7:0] OPEN_CHARS [3]  = '{CH_LPAREN, CH_LBRACKET, CH_LBRACE};
   localparam logic [7:0] CLOSE_CHARS [3] = '{CH_RPAREN, CH_RBRACKET, CH_RBRACE};

   // Tracks the operator stack and holds the postfix characters still owed.
   class postfix_scoreboard;
      logic [7:0]  op_stack [STACK_DEPTH];
      int unsigned depth_used;
      bit          ovf_sticky;
      rsp_type     pending [$];
      int unsigned errors;

      function new();
         depth_used = 0;
         ovf_sticky = 1'b0;
         errors     = 0;
      endfunction

      function int rank_of(logic [7:0] c);
         if (c == CH_PLUS || c == CH_MINUS) return 1;
         if (c == CH_STAR || c == CH_SLASH) return 2;
         if (c == CH_CARET) return 3;
         return -1;
      endfunction

      function void push_result(logic [7:0] sym, logic lst, logic ovf);
         rsp_type r;
         r.out_symbol = sym;
         r.last       = lst;
         r.overflow   = ovf;
         pending.push_back(r);
      endfunction

      function logic [7:0] pop_entry();
         depth_used--;
         return op_stack[depth_used];
      endfunction

      function void push_entry(logic [7:0] c);
         if (depth_used >= STACK_DEPTH) begin
            ovf_sticky = 1'b1;
         end else begin
            op_stack[depth_used] = c;
            depth_used++;
         end
      endfunction

      function void note_request(req_type item);
         logic [7:0] c;
         logic [7:0] opener;
         int         prec;
         c = item.symbol;
         if (item.end_of_expr) begin
            while (depth_used > 0) push_result(pop_entry(), 1'b0, 1'b0);
            push_result(CH_TERM, 1'b1, ovf_sticky);
            ovf_sticky = 1'b0;
         end else if ((c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
                      (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                      (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)) begin
            push_result(c, 1'b0, 1'b0);
         end else if (c == CH_LPAREN || c == CH_LBRACKET || c == CH_LBRACE) begin
            push_entry(c);
         end else if (c == CH_RPAREN || c == CH_RBRACKET || c == CH_RBRACE) begin
            opener = (c == CH_RPAREN) ? CH_LPAREN : (c == CH_RBRACKET) ? CH_LBRACKET : CH_LBRACE;
            while (depth_used > 0 && op_stack[depth_used - 1] != opener)
               push_result(pop_entry(), 1'b0, 1'b0);
            // drop the matching opener; an unmatched closer has emptied the stack
            if (depth_used > 0) void'(pop_entry());
         end else begin
            prec = rank_of(c);
            while (depth_used > 0 && prec <= rank_of(op_stack[depth_used - 1]))
               push_result(pop_entry(), 1'b0, 1'b0);
            push_entry(c);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected transfer: out_symbol %02h last %0b overflow %0b",
                   got.out_symbol, got.last, got.overflow);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.out_symbol !== want.out_symbol) begin
            $error("out_symbol: expected %02h, got %02h", want.out_symbol, got.out_symbol);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            errors++;
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   postfix_scoreboard sb;
   req_type           stimulus [$];
   int                rx_cycle = 0;

   always #1 clock = ~clock;

   infix_to_postfix_converter_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   task automatic add_char(input logic [7:0] c);
      stimulus.push_back(req_type'{symbol: c, end_of_expr: 1'b0});
   endtask

   // the symbol of an end item is ignored, so randomize it
   task automatic add_end();
      stimulus.push_back(req_type'{symbol: 8'($urandom_range(255)), end_of_expr: 1'b1});
   endtask

   function automatic logic [7:0] rand_operand();
      int pick;
      pick = $urandom_range(61);
      if (pick < 26) return CH_LOWER_A + 8'(pick);
      if (pick < 52) return CH_UPPER_A + 8'(pick - 26);
      return CH_DIGIT_0 + 8'(pick - 52);
   endfunction

   task automatic gen_expression(input bit broken);
      int len;
      int pick;
      int which;
      int open_q [$];
      len = $urandom_range(3, 16);
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            add_char(rand_operand());
         end else if (pick < 70) begin
            add_char(OP_CHARS[$urandom_range(4)]);
         end else if (pick < 82) begin
            which = $urandom_range(2);
            open_q.push_back(which);
            add_char(OPEN_CHARS[which]);
         end else if (pick < 94) begin
            if (!broken && open_q.size() > 0) add_char(CLOSE_CHARS[open_q.pop_back()]);
            else add_char(CLOSE_CHARS[$urandom_range(2)]);
         end else begin
            add_char(8'($urandom_range(255)));
         end
      end
      if (!broken) while (open_q.size() > 0) add_char(CLOSE_CHARS[open_q.pop_back()]);
      add_end();
   endtask

   // nest from 4 below to 6 past the stack depth, now and then an operand in between
   task automatic gen_deep();
      int n;
      n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(9) == 0) add_char(rand_operand());
         add_char(OPEN_CHARS[$urandom_range(2)]);
      end
      add_end();
   endtask

   task automatic build_stimulus();
      int target;
      int pick;
      add_char("a"); add_char(CH_PLUS); add_char("Z"); add_char(CH_STAR);
      add_char(CH_LPAREN); add_char("0"); add_char(CH_MINUS); add_char("9");
      add_char(CH_RPAREN); add_char(CH_CARET); add_char("A"); add_char(CH_CARET);
      add_char("z"); add_char(CH_SLASH); add_char(CH_LBRACKET); add_char(CH_LBRACE);
      add_char("b"); add_char(CH_RBRACKET);
      add_char(8'hFF);          // unknown operator pops everything
      add_char(CH_LPAREN);
      add_char(8'h00);          // zero as data, pops the bracket too
      add_char(CH_RBRACE);      // unmatched closer
      stimulus.push_back(req_type'{symbol: 8'hFF, end_of_expr: 1'b1});
      add_end();                // terminator on an empty stack
      target = RANDOM_ITEMS;
      gen_deep();
      while (stimulus.size() < target) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            gen_expression(1'b0);
         end else if (pick < 80) begin
            gen_expression(1'b1);
         end else if (pick < 92) begin
            for (int k = $urandom_range(4, 12); k > 0; k--) add_char(8'($urandom_range(255)));
            if ($urandom_range(1)) add_end();
         end else begin
            gen_deep();
         end
      end
      add_end();
   endtask

   task automatic send_item(input req_type item, input bit calm);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   initial begin : driver
      sb = new();
      build_stimulus();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (stimulus[idx])
         send_item(stimulus[idx], idx >= TX_CALM_FIRST && idx <= TX_CALM_LAST);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("infix_to_postfix_converter_core regression: pass");
      else
         $display("infix_to_postfix_converter_core regression: fail");
      $finish;
   end

   // receiver: random stalls, one long hold-off, one calm stretch
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
         rsp_ready <= 1'b0;
      else if (rx_cycle >= RX_CALM_START && rx_cycle < RX_CALM_END)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("infix_to_postfix_converter_core regression: fail");
      $finish;
   end

endmodule
